@@ sv/apdu_pkg.sv @@
// Shared types and constants for the APDU command parser.
// No dependencies; the top level and the checker use it by scoped names.

package apdu_pkg;

    // Command case codes carried on the summary word.
    localparam logic [2:0] CASE_1      = 3'd0;
    localparam logic [2:0] CASE_2S     = 3'd1;
    localparam logic [2:0] CASE_3S     = 3'd2;
    localparam logic [2:0] CASE_4S     = 3'd3;
    localparam logic [2:0] CASE_2E     = 3'd4;
    localparam logic [2:0] CASE_3E     = 3'd5;
    localparam logic [2:0] CASE_4E     = 3'd6;

    // Result kinds.
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Le values for a zero encoding.
    localparam logic [16:0] LE_SHORT_ZERO = 17'd256;
    localparam logic [16:0] LE_EXT_ZERO   = 17'd65536;

    // Saturation limit of the byte counter.
    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    // Number of header bytes kept (CLA, INS, P1, P2 and the fifth byte).
    localparam int HDR_BYTES = 5;

    // Output queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  body_byte;
        logic [7:0]  class_byte;
        logic [7:0]  instruction_byte;
        logic [7:0]  param_one;
        logic [7:0]  param_two;
        logic [15:0] body_length;
        logic [16:0] expected_length;
        logic [2:0]  command_case;
        logic        format_error;
        logic        run_end;
    } t_result;

endpackage

@@ sv/apdu_if.sv @@
// Valid/ready channel interfaces for the APDU command parser.
// No dependencies; the result fields are declared one by one.

interface apdu_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte;
    logic       final_byte;

    modport source (output valid, output cmd_byte, output final_byte, input ready);
    modport sink   (input valid, input cmd_byte, input final_byte, output ready);
endinterface

interface apdu_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  body_byte;
    logic [7:0]  class_byte;
    logic [7:0]  instruction_byte;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [15:0] body_length;
    logic [16:0] expected_length;
    logic [2:0]  command_case;
    logic        format_error;
    logic        run_end;

    modport source (
        output valid, output result_kind, output body_byte, output class_byte,
        output instruction_byte, output param_one, output param_two,
        output body_length, output expected_length, output command_case,
        output format_error, output run_end, input ready
    );
    modport sink (
        input valid, input result_kind, input body_byte, input class_byte,
        input instruction_byte, input param_one, input param_two,
        input body_length, input expected_length, input command_case,
        input format_error, input run_end, output ready
    );
endinterface

@@ sv/apdu_command_parser.sv @@
// Top level of the APDU command parser: byte counter, header capture,
// case decode and a small output queue. Depends on apdu_pkg and apdu_if.
//
//   channel | dir | payload                                   | handshake
//   i_cmd   | in  | cmd_byte, final_byte                      | valid/ready
//   o_res   | out | kind, body byte, header, Lc, Le, case, err | valid/ready
//
// A byte is decoded in the cycle it is accepted and its result words (none,
// one or two) are written to a four-word output queue; a byte can be taken
// every cycle while ready is high. The first result word is queued the cycle
// after acceptance. Input ready is high while the queue has room for two
// words, so a stalled sink stops input once fewer than two slots are free.
// Reset (synchronous, active low) clears the counter, header and queue.

module apdu_command_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    apdu_cmd_if.sink        i_cmd,
    apdu_res_if.source      o_res
);

    // Parser state.
    logic [16:0] r_pos;
    logic [7:0]  r_hdr [apdu_pkg::HDR_BYTES];
    logic [15:0] r_len;
    logic [7:0]  r_prev;

    // Output queue.
    apdu_pkg::t_result              r_fifo [apdu_pkg::FIFO_DEPTH];
    logic [apdu_pkg::FIFO_AW-1:0]   r_wr;
    logic [apdu_pkg::FIFO_AW-1:0]   r_rd;
    logic [apdu_pkg::FIFO_CW-1:0]   r_count;

    logic [7:0]  n_hdr [apdu_pkg::HDR_BYTES];
    logic [15:0] n_len;
    logic [7:0]  hdr4;
    logic        is_data;
    logic        in_acc;
    logic        out_acc;
    logic        fin;
    logic [7:0]  b;
    logic [2:0]  cs;
    logic [15:0] lc;
    logic [16:0] le;
    logic        err;
    logic [15:0] ext_le;
    apdu_pkg::t_result res_data;
    apdu_pkg::t_result res_sum;
    apdu_pkg::t_result head;
    logic [apdu_pkg::FIFO_CW-1:0] push_cnt;

    assign b       = i_cmd.cmd_byte;
    assign fin     = i_cmd.final_byte;
    assign in_acc  = i_cmd.valid && i_cmd.ready;
    assign out_acc = o_res.valid && o_res.ready;

    // Header and length bytes including the byte now arriving.
    always_comb begin
        for (int k = 0; k < apdu_pkg::HDR_BYTES; k++) begin
            n_hdr[k] = r_hdr[k];
        end
        n_len = r_len;
        if (r_pos < 17'd5) begin
            n_hdr[r_pos[2:0]] = b;
        end else if (r_pos == 17'd5) begin
            n_len = {b, r_len[7:0]};
        end else if (r_pos == 17'd6) begin
            n_len = {r_len[15:8], b};
        end
    end

    assign hdr4 = n_hdr[4];

    // A body byte falls inside the Lc span; it is passed on before the
    // message is known to be well formed.
    always_comb begin
        is_data = 1'b0;
        if (r_pos >= 17'd5) begin
            if (hdr4 != 8'd0) begin
                is_data = r_pos < ({9'd0, hdr4} + 17'd5);
            end else if (r_pos >= 17'd7 && n_len != 16'd0) begin
                is_data = r_pos < ({1'b0, n_len} + 17'd7);
            end
        end
    end

    assign ext_le = {r_prev, b};

    // Case decode on the final byte; message length is r_pos + 1.
    always_comb begin
        cs  = apdu_pkg::CASE_1;
        lc  = 16'd0;
        le  = 17'd0;
        err = 1'b0;
        if (r_pos < 17'd3) begin
            err = 1'b1;
        end else if (r_pos == 17'd3) begin
            cs = apdu_pkg::CASE_1;
        end else if (r_pos == 17'd4) begin
            cs = apdu_pkg::CASE_2S;
            le = (hdr4 == 8'd0) ? apdu_pkg::LE_SHORT_ZERO : {9'd0, hdr4};
        end else if (hdr4 == 8'd0 && r_pos >= 17'd6) begin
            if (n_len == 16'd0) begin
                // Extended form with Lc zero takes any trailing bytes.
                cs = apdu_pkg::CASE_2E;
                le = apdu_pkg::LE_EXT_ZERO;
            end else if (r_pos == {1'b0, n_len} + 17'd6) begin
                cs = apdu_pkg::CASE_3E;
                lc = n_len;
            end else if (r_pos == {1'b0, n_len} + 17'd8) begin
                cs = apdu_pkg::CASE_4E;
                lc = n_len;
                le = (ext_le == 16'd0) ? apdu_pkg::LE_EXT_ZERO : {1'b0, ext_le};
            end else begin
                err = 1'b1;
            end
        end else begin
            // A six-byte message with a zero fifth byte lands here as case 2S.
            if (hdr4 == 8'd0) begin
                cs = apdu_pkg::CASE_2S;
                le = apdu_pkg::LE_SHORT_ZERO;
            end else if (r_pos == {9'd0, hdr4} + 17'd4) begin
                cs = apdu_pkg::CASE_3S;
                lc = {8'd0, hdr4};
            end else if (r_pos == {9'd0, hdr4} + 17'd5) begin
                cs = apdu_pkg::CASE_4S;
                lc = {8'd0, hdr4};
                le = (b == 8'd0) ? apdu_pkg::LE_SHORT_ZERO : {9'd0, b};
            end else begin
                err = 1'b1;
            end
        end
        if (err) begin
            cs = apdu_pkg::CASE_1;
            lc = 16'd0;
            le = 17'd0;
        end
    end

    always_comb begin
        res_data             = '0;
        res_data.result_kind = apdu_pkg::KIND_DATA;
        res_data.body_byte   = b;
        res_data.run_end     = !fin;

        res_sum                  = '0;
        res_sum.result_kind      = apdu_pkg::KIND_SUMMARY;
        res_sum.class_byte       = n_hdr[0];
        res_sum.instruction_byte = n_hdr[1];
        res_sum.param_one        = n_hdr[2];
        res_sum.param_two        = n_hdr[3];
        res_sum.body_length      = lc;
        res_sum.expected_length  = le;
        res_sum.command_case     = cs;
        res_sum.format_error     = err;
        res_sum.run_end          = 1'b1;
    end

    assign push_cnt = in_acc
        ? (apdu_pkg::FIFO_CW'(is_data) + apdu_pkg::FIFO_CW'(fin))
        : '0;

    // Parser state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_prev <= '0;
            for (int k = 0; k < apdu_pkg::HDR_BYTES; k++) begin
                r_hdr[k] <= '0;
            end
        end else if (in_acc) begin
            if (fin) begin
                r_pos  <= '0;
                r_len  <= '0;
                r_prev <= '0;
                for (int k = 0; k < apdu_pkg::HDR_BYTES; k++) begin
                    r_hdr[k] <= '0;
                end
            end else begin
                r_prev <= b;
                if (r_pos != apdu_pkg::POS_MAX) begin
                    r_pos <= r_pos + 17'd1;
                end
                r_len <= n_len;
                for (int k = 0; k < apdu_pkg::HDR_BYTES; k++) begin
                    r_hdr[k] <= n_hdr[k];
                end
            end
        end
    end

    // Output queue: the data word, when present, goes in ahead of the summary.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (is_data) begin
                r_fifo[r_wr] <= res_data;
                if (fin) begin
                    r_fifo[r_wr + apdu_pkg::FIFO_AW'(1)] <= res_sum;
                end
            end else if (fin) begin
                r_fifo[r_wr] <= res_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + apdu_pkg::FIFO_AW'(push_cnt);
            r_rd    <= r_rd + apdu_pkg::FIFO_AW'(out_acc);
            r_count <= r_count + push_cnt - apdu_pkg::FIFO_CW'(out_acc);
        end
    end

    assign i_cmd.ready = r_count <= apdu_pkg::FIFO_CW'(apdu_pkg::FIFO_DEPTH - 2);

    assign head                   = r_fifo[r_rd];
    assign o_res.valid            = r_count != '0;
    assign o_res.result_kind      = head.result_kind;
    assign o_res.body_byte        = head.body_byte;
    assign o_res.class_byte       = head.class_byte;
    assign o_res.instruction_byte = head.instruction_byte;
    assign o_res.param_one        = head.param_one;
    assign o_res.param_two        = head.param_two;
    assign o_res.body_length      = head.body_length;
    assign o_res.expected_length  = head.expected_length;
    assign o_res.command_case     = head.command_case;
    assign o_res.format_error     = head.format_error;
    assign o_res.run_end          = head.run_end;

    // The queue never holds more words than it has slots.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= apdu_pkg::FIFO_CW'(apdu_pkg::FIFO_DEPTH))
        else $error("output queue overflow");

    // A final byte returns the parser to the start of a message.
    a_clear_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && fin) |=> (r_pos == 17'd0 && r_len == 16'd0))
        else $error("parser state not cleared after final byte");

    // A format error never carries a length or case.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.result_kind == apdu_pkg::KIND_SUMMARY && o_res.format_error)
        |-> (o_res.body_length == 16'd0 && o_res.expected_length == 17'd0
             && o_res.command_case == apdu_pkg::CASE_1))
        else $error("format error summary carries length fields");

    // A data word is never the last word of a final byte.
    a_data_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && fin && is_data) |=> (r_fifo[$past(r_wr)].run_end == 1'b0))
        else $error("data word on final byte marked as run end");

endmodule

@@ tb/apdu_parser_checker.sv @@
// Checker for the APDU command parser: decodes every accepted command byte on its
// own and compares each accepted result word with the oldest word it expects.
// Depends on apdu_pkg and the channel interfaces in apdu_if.

module apdu_parser_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    apdu_cmd_if     i_cmd,
    apdu_res_if     i_res,
    output int      o_fail_count,
    output int      o_pending
);

    logic [16:0] msg_pos;
    logic [7:0]  hdr [apdu_pkg::HDR_BYTES];
    logic [15:0] lc_field;
    logic [7:0]  last_byte;

    apdu_pkg::t_result awaited_words [$];
    int fail_count = 0;
    int awaited_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = awaited_count;

    task report_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    task check_field(input string name, input logic [16:0] got, input logic [16:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    task clear_message();
        msg_pos   = '0;
        lc_field  = '0;
        last_byte = '0;
        foreach (hdr[i]) hdr[i] = '0;
    endtask

    task decode_byte(input logic [7:0] b, input logic fin);
        int unsigned       p;
        int unsigned       len;
        int unsigned       lc;
        logic [16:0]       le;
        logic [2:0]        cs;
        logic              err;
        logic              in_body;
        apdu_pkg::t_result w;

        p = msg_pos;
        if (p < apdu_pkg::HDR_BYTES) hdr[p] = b;
        else if (p == 5) lc_field[15:8] = b;
        else if (p == 6) lc_field[7:0] = b;

        // Body bytes are forwarded as they stream, before the length is known to fit.
        in_body = 1'b0;
        if (p >= 5) begin
            if (hdr[4] != 8'd0) in_body = (p < 5 + hdr[4]);
            else if (p >= 7 && lc_field != 16'd0) in_body = (p < 7 + lc_field);
        end

        if (in_body) begin
            w = '0;
            w.result_kind = apdu_pkg::KIND_DATA;
            w.body_byte   = b;
            w.run_end     = !fin;
            awaited_words.push_back(w);
        end

        if (fin) begin
            len = p + 1;
            lc  = 0;
            le  = '0;
            cs  = apdu_pkg::CASE_1;
            err = 1'b0;
            if (len < 4) begin
                err = 1'b1;
            end else if (len == 4) begin
                cs = apdu_pkg::CASE_1;
            end else if (len == 5) begin
                cs = apdu_pkg::CASE_2S;
                le = (hdr[4] == 8'd0) ? apdu_pkg::LE_SHORT_ZERO : {9'd0, hdr[4]};
            end else if (hdr[4] == 8'd0 && len >= 7) begin
                if (lc_field == 16'd0) begin
                    cs = apdu_pkg::CASE_2E;
                    le = apdu_pkg::LE_EXT_ZERO;
                end else if (len == 7 + lc_field) begin
                    cs = apdu_pkg::CASE_3E;
                    lc = lc_field;
                end else if (len == 9 + lc_field) begin
                    cs = apdu_pkg::CASE_4E;
                    lc = lc_field;
                    le = ({last_byte, b} == 16'd0) ? apdu_pkg::LE_EXT_ZERO
                                                   : {1'b0, last_byte, b};
                end else begin
                    err = 1'b1;
                end
            end else begin
                // A six-byte message with a zero fifth byte lands here as well.
                if (hdr[4] == 8'd0) begin
                    cs = apdu_pkg::CASE_2S;
                    le = apdu_pkg::LE_SHORT_ZERO;
                end else if (len == 5 + hdr[4]) begin
                    cs = apdu_pkg::CASE_3S;
                    lc = hdr[4];
                end else if (len == 6 + hdr[4]) begin
                    cs = apdu_pkg::CASE_4S;
                    lc = hdr[4];
                    le = (b == 8'd0) ? apdu_pkg::LE_SHORT_ZERO : {9'd0, b};
                end else begin
                    err = 1'b1;
                end
            end
            if (err) begin
                lc = 0;
                le = '0;
                cs = apdu_pkg::CASE_1;
            end

            w = '0;
            w.result_kind      = apdu_pkg::KIND_SUMMARY;
            w.class_byte       = hdr[0];
            w.instruction_byte = hdr[1];
            w.param_one        = hdr[2];
            w.param_two        = hdr[3];
            w.body_length      = lc[15:0];
            w.expected_length  = le;
            w.command_case     = cs;
            w.format_error     = err;
            w.run_end          = 1'b1;
            awaited_words.push_back(w);
            clear_message();
        end else begin
            last_byte = b;
            if (msg_pos != apdu_pkg::POS_MAX) msg_pos = msg_pos + 17'd1;
        end
    endtask

    task check_result();
        apdu_pkg::t_result want;
        if (awaited_words.size() == 0) begin
            report_mismatch($sformatf("result word of kind %0d with no word awaited",
                                      i_res.result_kind));
        end else begin
            want = awaited_words.pop_front();
            check_field("result_kind", i_res.result_kind, want.result_kind);
            check_field("body_byte", i_res.body_byte, want.body_byte);
            check_field("class_byte", i_res.class_byte, want.class_byte);
            check_field("instruction_byte", i_res.instruction_byte, want.instruction_byte);
            check_field("param_one", i_res.param_one, want.param_one);
            check_field("param_two", i_res.param_two, want.param_two);
            check_field("body_length", i_res.body_length, want.body_length);
            check_field("expected_length", i_res.expected_length, want.expected_length);
            check_field("command_case", i_res.command_case, want.command_case);
            check_field("format_error", i_res.format_error, want.format_error);
            check_field("run_end", i_res.run_end, want.run_end);
        end
    endtask

    // A result word accepted at this edge was caused by an earlier byte, so it
    // is checked before the byte accepted at the same edge is decoded.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            awaited_words.delete();
        end else begin
            if (i_res.valid && i_res.ready) check_result();
            if (i_cmd.valid && i_cmd.ready) decode_byte(i_cmd.cmd_byte, i_cmd.final_byte);
        end
        awaited_count <= awaited_words.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the APDU command parser testbench: clock, reset, command byte stimulus,
// result stalls and the verdict. Depends on apdu_if, the parser and
// apdu_parser_checker.

module testbench;

    localparam int QUIET_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    logic [7:0] msg_bytes [$];

    apdu_cmd_if cmd_ch ();
    apdu_res_if res_ch ();

    apdu_command_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    apdu_parser_checker parse_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 clk = ~clk;

    // Any cycle that moves a word on either channel restarts the count.
    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task send_word(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd_byte   <= value;
        cmd_ch.final_byte <= last;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task send_message();
        foreach (msg_bytes[i]) send_word(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task drain_results();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task add_random(input int count);
        repeat (count) msg_bytes.push_back(8'($urandom_range(255)));
    endtask

    task add_ext_lc(input int lc);
        msg_bytes.push_back(8'h00);
        msg_bytes.push_back(8'(lc >> 8));
        msg_bytes.push_back(8'(lc));
    endtask

    function automatic int short_lc();
        return ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
    endfunction

    function automatic int ext_lc();
        return ($urandom_range(9) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 12);
    endfunction

    // Mostly well-formed commands of every case with random content; the rest
    // are wrong lengths, truncated headers and plain noise.
    task build_random_message();
        int kind;
        int lc;
        msg_bytes.delete();
        add_random(4);
        kind = $urandom_range(0, 19);
        case (kind)
            0: ;
            1: add_random(1);
            2, 3: begin
                lc = short_lc();
                msg_bytes.push_back(8'(lc));
                add_random(lc);
            end
            4, 5: begin
                lc = short_lc();
                msg_bytes.push_back(8'(lc));
                add_random(lc);
                if ($urandom_range(3) == 0) msg_bytes.push_back(8'h00);
                else add_random(1);
            end
            6: begin
                add_ext_lc(0);
                add_random($urandom_range(0, 4));
            end
            7, 8: begin
                lc = ext_lc();
                add_ext_lc(lc);
                add_random(lc);
            end
            9, 10: begin
                lc = ext_lc();
                add_ext_lc(lc);
                add_random(lc);
                if ($urandom_range(3) == 0) begin
                    msg_bytes.push_back(8'h00);
                    msg_bytes.push_back(8'h00);
                end else begin
                    add_random(2);
                end
            end
            11: begin
                msg_bytes.push_back(8'h00);
                add_random(1);
            end
            12, 13: begin
                lc = short_lc();
                msg_bytes.push_back(8'(lc));
                add_random($urandom_range(0, 1) ? lc + $urandom_range(2, 5) : lc - 1);
            end
            14: begin
                lc = ext_lc();
                add_ext_lc(lc);
                add_random($urandom_range(0, 1) ? lc + 1 : lc + 3);
            end
            15: begin
                msg_bytes.delete();
                add_random($urandom_range(1, 3));
            end
            default: add_random($urandom_range(0, 12));
        endcase
    endtask

    task run_random(input int byte_budget);
        int sent;
        sent = 0;
        while (sent < byte_budget) begin
            build_random_message();
            sent += msg_bytes.size();
            send_message();
            if ($urandom_range(29) == 0) drain_results();
        end
    endtask

    initial begin
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd_byte   = 8'h00;
        cmd_ch.final_byte = 1'b0;
        rst_n             = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 15;
        recv_stall_pct = 48;

        // Too short, bare header, short Le of zero, the six-byte form with a
        // zero fifth byte, and a body byte that also ends the command.
        msg_bytes = '{8'hFF};
        send_message();
        msg_bytes = '{8'h00, 8'hFF, 8'h00};
        send_message();
        msg_bytes = '{8'h80, 8'hCA, 8'h00, 8'hFF};
        send_message();
        msg_bytes = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00};
        send_message();
        msg_bytes = '{8'h00, 8'hB0, 8'h01, 8'h02, 8'h00, 8'h7E};
        send_message();
        msg_bytes = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h01, 8'hFF};
        send_message();
        drain_results();

        run_random(250);
        drain_results();

        send_idle_pct  = 48;
        recv_stall_pct = 15;
        run_random(250);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(250);
        msg_bytes.delete();

        drain_results();
        repeat (16) @(negedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/apdu_pkg.sv
sv/apdu_if.sv
sv/apdu_command_parser.sv
tb/apdu_parser_checker.sv
tb/testbench.sv
